// ----- rtl/core/hmnt_pkg.sv -----
// Shared types, codes and hash constants for the sorted node table.
// Used by hmnt_cell, hmnt_hash and hash_mod_node_table_unit; depends on nothing.
package hmnt_pkg;

  localparam int unsigned MaxNodesDefault = 16;
  localparam int unsigned HashW           = 64;
  localparam int unsigned IdW             = 32;
  localparam int unsigned DataW           = 32;
  localparam int unsigned FoundIdxW       = 4;

  localparam logic [HashW-1:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOCATE = 2'd1,
    ACT_NEXT   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_NONE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DIV,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [DataW-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   ins;
    entry_t key;
  } cell_ctrl_t;

  typedef struct packed {
    logic fold;
    logic clear;
    logic div_start;
  } hash_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hash_sts_t;

  // Multiply by the FNV 64 prime 2^40 + 0x1B3, written as shifts and adds.
  function automatic logic [HashW-1:0] fnv_mult(input logic [HashW-1:0] h);
    fnv_mult = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

endpackage

// ----- rtl/core/hmnt_cell.sv -----
// One table slot of the sorted node chain: holds an entry, compares it with
// the key and shifts in its left neighbor on insert. Depends on hmnt_pkg.
module hmnt_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hmnt_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]     count_i,
  input  hmnt_pkg::entry_t    left_entry_i,
  input  logic                left_lt_i,
  output hmnt_pkg::entry_t    entry_o,
  output logic                lt_o,
  output logic                eq_o
);
  import hmnt_pkg::*;

  entry_t entry_q, entry_d;
  logic   valid;
  logic   take_new, take_left;

  assign valid = count_i > CntW'(Index);
  assign lt_o  = valid && (entry_q.id < ctrl_i.key.id);
  assign eq_o  = valid && (entry_q.id == ctrl_i.key.id);

  // The key lands where the left neighbor is smaller and this one is not;
  // every slot above that point moves one place up.
  assign take_new  = ctrl_i.ins && !lt_o && left_lt_i;
  assign take_left = ctrl_i.ins && !lt_o && !left_lt_i;

  always_comb begin
    entry_d = entry_q;
    if (take_new) begin
      entry_d = ctrl_i.key;
    end else if (take_left) begin
      entry_d = left_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

  if (Index != 0) begin : g_order_chk
    logic left_valid;
    assign left_valid = count_i >= CntW'(Index);
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (valid && left_valid) |-> (left_entry_i.id < entry_q.id))
      else $error("table slots out of ascending order");
  end

endmodule

// ----- rtl/core/hmnt_hash.sv -----
// FNV-1a 64 running hash with a bit-serial remainder unit for the final
// hash mod entry count. Depends on hmnt_pkg.
module hmnt_hash #(
  parameter int unsigned CntW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hmnt_pkg::hash_ctrl_t  ctrl_i,
  input  logic [7:0]            byte_i,
  input  logic [CntW-1:0]       divisor_i,
  output hmnt_pkg::hash_sts_t   sts_o,
  output logic [CntW-1:0]       rem_o
);
  import hmnt_pkg::*;

  localparam int unsigned StepW = $clog2(HashW);

  logic [HashW-1:0] hash_q, hash_d, hash_next;
  logic [HashW-1:0] sh_q, sh_d;
  logic [CntW-1:0]  rem_q, rem_d, div_q;
  logic [CntW:0]    trial;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;

  assign hash_next = ctrl_i.fold ? fnv_mult(hash_q ^ HashW'(byte_i)) : hash_q;
  assign hash_d    = ctrl_i.clear ? FnvBasis : hash_next;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  assign trial = {rem_q, sh_q[HashW-1]};

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.div_start) begin
      sh_d   = hash_next;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d   = sh_q << 1;
      rem_d  = (trial >= {1'b0, div_q}) ? CntW'(trial - {1'b0, div_q}) : CntW'(trial);
      step_d = step_q + 1'b1;
      if (step_q == StepW'(HashW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (ctrl_i.div_start) begin
      div_q <= divisor_i;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

// ----- rtl/core/hash_mod_node_table_unit.sv -----
// Sorted node table with FNV-1a 64 placement. One word is taken at a time; an add or a
// next-after passes through the execute and response states, a locate byte without the
// last mark folds and returns to idle, and the last byte of a name waits, unless the table
// is empty, for the bit-serial 64-bit remainder against the entry count. The table itself
// is a chain of MaxNodes cells that shift on insert. The output word is registered, so a
// waiting result does not stop the next word from being taken. No clearing pass after reset.
module hash_mod_node_table_unit #(
  parameter int unsigned MaxNodes = hmnt_pkg::MaxNodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // node_id[31:0], node_data[63:32], name_byte[71:64]
  input  logic [2:0]  s_axis_tuser_i,  // action[1:0], has_byte[2]
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // found_id[31:0], found_data[63:32], found_index[67:64]
  output logic [2:0]  m_axis_tuser_o   // status[2:0]
);
  import hmnt_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxNodes);
  localparam int unsigned CntW = $clog2(MaxNodes + 1);

  fsm_e state_q, state_d;

  logic [1:0]       act_q;
  entry_t           key_q;
  logic [7:0]       byte_q;
  logic             has_q, last_q;
  logic [CntW-1:0]  count_q;
  logic [IdxW-1:0]  sel_q, sel_d;
  status_e          res_q, res_d;
  logic             sel_we, count_inc, out_load, accept;

  logic             out_valid_q, out_free;
  status_e          out_status_q;
  entry_t           out_entry_q;
  logic [FoundIdxW-1:0] out_idx_q;

  cell_ctrl_t       cell_ctrl;
  hash_ctrl_t       hash_ctrl;
  hash_sts_t        hash_sts;
  logic [CntW-1:0]  rem;

  entry_t           cell_entry [MaxNodes];
  logic [MaxNodes-1:0] lt_vec, eq_vec;

  logic             dup, full;
  logic [IdxW-1:0]  match_idx, pos, nx;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Cell chain.
  for (genvar i = 0; i < MaxNodes; i++) begin : g_cell
    hmnt_cell #(
      .Index (i),
      .CntW  (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .count_i      (count_q),
      .left_entry_i (i == 0 ? key_q : cell_entry[(i == 0) ? 0 : i - 1]),
      .left_lt_i    (i == 0 ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
      .entry_o      (cell_entry[i]),
      .lt_o         (lt_vec[i]),
      .eq_o         (eq_vec[i])
    );
  end

  hmnt_hash #(
    .CntW (CntW)
  ) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hash_ctrl),
    .byte_i    (byte_q),
    .divisor_i (count_q),
    .sts_o     (hash_sts),
    .rem_o     (rem)
  );

  // Match and insert-position decode over the cell flags.
  always_comb begin
    match_idx = '0;
    pos       = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      if (eq_vec[i]) begin
        match_idx = IdxW'(i);
      end
      if (lt_vec[i]) begin
        pos = IdxW'(i + 1);
      end
    end
    dup  = |eq_vec;
    full = count_q == CntW'(MaxNodes);
    // Successor wraps to slot zero after the last entry; a miss also picks slot zero.
    if (dup && (CntW'(match_idx) + CntW'(1) != count_q)) begin
      nx = match_idx + 1'b1;
    end else begin
      nx = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        case (act_q)
          ACT_ADD:  state_d = FSM_RESP;
          ACT_NEXT: state_d = FSM_RESP;
          ACT_LOCATE: begin
            if (!last_q) begin
              state_d = FSM_IDLE;
            end else if (count_q == '0) begin
              state_d = FSM_RESP;
            end else begin
              state_d = FSM_DIV;
            end
          end
          default: state_d = FSM_IDLE;
        endcase
      end
      FSM_DIV: begin
        if (hash_sts.done) begin
          state_d = FSM_RESP;
        end
      end
      FSM_RESP: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready_o     = 1'b0;
    cell_ctrl.key       = key_q;
    cell_ctrl.ins       = 1'b0;
    hash_ctrl.fold      = 1'b0;
    hash_ctrl.clear     = 1'b0;
    hash_ctrl.div_start = 1'b0;
    sel_we              = 1'b0;
    sel_d               = '0;
    res_d               = ST_OK;
    count_inc           = 1'b0;
    out_load            = 1'b0;
    case (state_q)
      FSM_IDLE: s_axis_tready_o = 1'b1;
      FSM_EXEC: begin
        case (act_q)
          ACT_ADD: begin
            sel_we = 1'b1;
            if (dup) begin
              res_d = ST_DUP;
              sel_d = match_idx;
            end else if (full) begin
              res_d = ST_FULL;
            end else begin
              cell_ctrl.ins = 1'b1;
              count_inc     = 1'b1;
              sel_d         = pos;
            end
          end
          ACT_LOCATE: begin
            hash_ctrl.fold = has_q;
            if (last_q) begin
              hash_ctrl.clear     = 1'b1;
              hash_ctrl.div_start = count_q != '0;
              sel_we              = 1'b1;
              res_d               = (count_q == '0) ? ST_EMPTY : ST_OK;
            end
          end
          ACT_NEXT: begin
            sel_we = 1'b1;
            if (count_q <= CntW'(1)) begin
              res_d = ST_NONE;
            end else begin
              sel_d = nx;
            end
          end
          default: ;
        endcase
      end
      FSM_DIV: begin
        if (hash_sts.done) begin
          sel_we = 1'b1;
          sel_d  = IdxW'(rem);
          res_d  = ST_OK;
        end
      end
      FSM_RESP: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (count_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= s_axis_tuser_i[1:0];
      has_q      <= s_axis_tuser_i[2];
      key_q.id   <= s_axis_tdata_i[31:0];
      key_q.data <= s_axis_tdata_i[63:32];
      byte_q     <= s_axis_tdata_i[71:64];
      last_q     <= s_axis_tlast_i;
    end
    if (sel_we) begin
      sel_q <= sel_d;
      res_q <= res_d;
    end
    if (out_load) begin
      out_status_q <= res_q;
      if (res_q == ST_OK || res_q == ST_DUP) begin
        out_entry_q <= cell_entry[sel_q];
        out_idx_q   <= FoundIdxW'(sel_q);
      end else begin
        out_entry_q <= '0;
        out_idx_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {4'b0000, out_idx_q, out_entry_q.data, out_entry_q.id};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxNodes))
    else $error("entry count beyond table size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == CntW'($past(count_q) + 1'b1)))
    else $error("entry count changed by other than one insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hash_sts.busy || hash_sts.done) |-> (state_q == FSM_DIV))
    else $error("remainder unit active outside the divide state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == FSM_RESP))
    else $error("result word raised outside the response state");

endmodule
